// File: src/infix_to_postfix_converter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the infix-to-postfix converter
// Property forms used by the converter's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define ITP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in a cycle implies the consequent in the same cycle.
`define ITP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Types, codes and defaults shared by the infix-to-postfix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

  localparam int unsigned DEFAULT_STACK_DEPTH = 32;

  // Token kinds
  localparam logic [2:0] CMD_NUMBER   = 3'd0;
  localparam logic [2:0] CMD_OPERATOR = 3'd1;
  localparam logic [2:0] CMD_LPAREN   = 3'd2;
  localparam logic [2:0] CMD_RPAREN   = 3'd3;
  localparam logic [2:0] CMD_END      = 3'd4;

  // Operator codes; a stacked left paren uses its own code
  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_SUB      = 3'd1;
  localparam logic [2:0] OP_MUL      = 3'd2;
  localparam logic [2:0] OP_DIV      = 3'd3;
  localparam logic [2:0] OP_MOD      = 3'd4;
  localparam logic [2:0] CODE_LPAREN = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_NUMBER   = 2'd0;
  localparam logic [1:0] KIND_OPERATOR = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_RPAREN   = 2'd2;
  localparam logic [1:0] ERR_LPAREN   = 2'd3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [2:0]         op_code;
    logic signed [31:0] number_value;
  } token_t;

  typedef struct packed {
    logic [1:0]         out_kind;
    logic [2:0]         out_op;
    logic signed [31:0] out_value;
    logic [1:0]         error_code;
    logic               last;
  } result_t;

  // One step of the stack walk, as chosen by the compare unit
  typedef struct packed {
    logic       pop;   // emit top as operator, shrink stack
    logic       drop;  // discard matched left paren, shrink stack
    logic       push;  // write operator at top, grow stack
    logic       fin;   // final result follows, stack is cleared
    logic [1:0] kind;
    logic [1:0] err;
  } decision_t;

endpackage

`default_nettype wire

// File: src/itp_ram.sv
// ----------------------------------------------------------------------------
// itp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/itp_decide.sv
// ----------------------------------------------------------------------------
// itp_decide
// Precedence compare unit: picks the next stack action for the token.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_decide import itp_pkg::*; (
  input  wire logic [2:0] cmd,
  input  wire logic [2:0] op,
  input  wire logic [2:0] top,
  input  wire logic       empty,
  input  wire logic       full,
  output      decision_t  dec
);

  function automatic logic [1:0] prec_of(input logic [2:0] code);
    logic [1:0] p;
    p = 2'd0;
    if (code inside {OP_MUL, OP_DIV, OP_MOD}) begin
      p = 2'd2;
    end else if (code inside {OP_ADD, OP_SUB}) begin
      p = 2'd1;
    end
    return p;
  endfunction

  always_comb begin
    dec = '0;
    case (cmd)
      CMD_OPERATOR: begin
        if (!empty && (prec_of(top) >= prec_of(op))) begin
          dec.pop = 1'b1;
        end else if (full) begin
          dec.fin  = 1'b1;
          dec.kind = KIND_ERROR;
          dec.err  = ERR_OVERFLOW;
        end else begin
          dec.push = 1'b1;
        end
      end
      CMD_RPAREN: begin
        if (empty) begin
          dec.fin  = 1'b1;
          dec.kind = KIND_ERROR;
          dec.err  = ERR_RPAREN;
        end else if (top == CODE_LPAREN) begin
          dec.drop = 1'b1;
        end else begin
          dec.pop = 1'b1;
        end
      end
      CMD_END: begin
        if (empty) begin
          dec.fin  = 1'b1;
          dec.kind = KIND_END;
          dec.err  = ERR_NONE;
        end else if (top == CODE_LPAREN) begin
          dec.fin  = 1'b1;
          dec.kind = KIND_ERROR;
          dec.err  = ERR_LPAREN;
        end else begin
          dec.pop = 1'b1;
        end
      end
      default: begin
        dec = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix tokens in, postfix tokens out, with an
// operator stack held in RAM and walked by a small sequencer.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------
//   token   | in        | token_valid / token_ready  | token_t (token)
//   result  | out       | result_valid / result_ready| result_t (result)
//
// Steps: a left paren is taken in idle; a number or a left paren overflow goes
// to the final state. Operator, right paren or end: accept, then a RAM read and
// a compare per entry, a decision at an empty stack, final state on end or error.
// Reset (rst, synchronous) empties the stack and drops any pending result;
// the stack RAM itself is not cleared.
// A waiting result holds any further result; the next token is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

`include "infix_to_postfix_converter_assert.svh"

module infix_to_postfix_converter import itp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    token_valid,
  output      logic    token_ready,
  input  wire token_t  token,
  output      logic    result_valid,
  input  wire logic    result_ready,
  output      result_t result
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COMPARE,
    ST_FINAL
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;      // entries in use
  logic [2:0]         cmd_q;
  logic [2:0]         op_q;
  logic signed [31:0] value_q;
  logic               held_valid; // popped operator not yet known to be last
  logic [2:0]         held_op;
  logic [1:0]         fin_kind;
  logic [1:0]         fin_err;

  logic               accept;
  logic               out_free;
  logic               cnt_empty;
  logic               cnt_full;
  logic               lparen_push;
  logic               dec_active;
  logic               step;
  logic               emit_final;
  logic               emit_held;
  decision_t          dec;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [2:0]         ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [2:0]         ram_rdata;

  assign token_ready = (state == ST_IDLE);
  assign accept      = token_valid && token_ready;
  assign out_free    = !result_valid || result_ready;
  assign cnt_empty   = (count == '0);
  assign cnt_full    = (count == CW'(STACK_DEPTH));
  assign lparen_push = accept && (token.cmd == CMD_LPAREN) && !cnt_full;

  // Decide when the top entry is in hand, or at once when the stack is empty
  assign dec_active = (state == ST_COMPARE) || ((state == ST_READ) && cnt_empty);
  // Hold while a held operator has nowhere to go
  assign step       = dec_active && !(held_valid && !out_free);

  // Load the result register from the final stage or from the held operator
  assign emit_final = (state == ST_FINAL) && out_free;
  assign emit_held  = step && held_valid;

  assign ram_we    = lparen_push || (step && dec.push);
  assign ram_waddr = count[AW-1:0];
  assign ram_wdata = (state == ST_IDLE) ? CODE_LPAREN : op_q;
  assign ram_re    = (state == ST_READ) && !cnt_empty;
  assign ram_raddr = AW'(count - 1'b1);

  itp_ram #(
    .WIDTH (3),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  itp_decide u_decide (
    .cmd   (cmd_q),
    .op    (op_q),
    .top   (ram_rdata),
    .empty (cnt_empty),
    .full  (cnt_full),
    .dec   (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (emit_final || emit_held) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_q   <= token.cmd;
            op_q    <= token.op_code;
            value_q <= token.number_value;
            case (token.cmd)
              CMD_NUMBER: begin
                fin_kind <= KIND_NUMBER;
                fin_err  <= ERR_NONE;
                state    <= ST_FINAL;
              end
              CMD_OPERATOR: begin
                // drop operator codes that mean nothing
                if (token.op_code <= OP_MOD) begin
                  state <= ST_READ;
                end
              end
              CMD_LPAREN: begin
                if (cnt_full) begin
                  fin_kind <= KIND_ERROR;
                  fin_err  <= ERR_OVERFLOW;
                  count    <= '0;
                  state    <= ST_FINAL;
                end else begin
                  count <= count + 1'b1;
                end
              end
              CMD_RPAREN, CMD_END: begin
                state <= ST_READ;
              end
              default: begin
                // unknown token kind: ignore
              end
            endcase
          end
        end
        ST_READ: begin
          if (!cnt_empty) begin
            state <= ST_COMPARE;
          end
        end
        ST_COMPARE: begin
          // advanced by the step logic below
        end
        ST_FINAL: begin
          if (emit_final) begin
            result <= '{out_kind:   fin_kind,
                        out_op:     OP_ADD,
                        out_value:  (fin_kind == KIND_NUMBER) ? value_q : 32'sd0,
                        error_code: fin_err,
                        last:       1'b1};
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (step) begin
        // Hold the newly popped operator, if any, in place of the old one
        held_valid <= dec.pop;
        // Release the held operator; it is last unless more results follow
        if (held_valid) begin
          result <= '{out_kind:   KIND_OPERATOR,
                      out_op:     held_op,
                      out_value:  32'sd0,
                      error_code: ERR_NONE,
                      last:       !(dec.pop || dec.fin)};
        end
        if (dec.pop) begin
          held_op <= ram_rdata;
          count   <= count - 1'b1;
          state   <= ST_READ;
        end else if (dec.drop) begin
          count <= count - 1'b1;
          state <= ST_IDLE;
        end else if (dec.push) begin
          count <= count + 1'b1;
          state <= ST_IDLE;
        end else if (dec.fin) begin
          fin_kind <= dec.kind;
          fin_err  <= dec.err;
          count    <= '0;
          state    <= ST_FINAL;
        end else begin
          state <= ST_IDLE;
        end
      end
    end
  end

  `ITP_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(STACK_DEPTH), "stack count past depth")
  `ITP_ASSERT_IMPLY(a_idle_no_held, clk, rst, token_ready, !held_valid, "held operator left in idle")
  `ITP_ASSERT_IMPLY(a_push_room, clk, rst, ram_we, !cnt_full, "stack write while full")
  `ITP_ASSERT_IMPLY(a_final_no_held, clk, rst, state == ST_FINAL, !held_valid, "held operator behind final")

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: infix-to-postfix converter regression
// Drives infix token streams into the converter and checks every postfix
// result against an in-bench shunting-yard model, with random gaps and stalls
// on both channels.
// ----------------------------------------------------------------------------

module tb_top import itp_pkg::*;;

  localparam int unsigned STACK_DEPTH   = DEFAULT_STACK_DEPTH;
  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned RANDOM_ITEMS  = 160;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned REPORT_LIMIT  = 20;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN} rx_mode_t;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    token_valid  = 1'b0;
  logic    token_ready;
  token_t  token        = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  // Model state: operator stack and its fill level
  logic [2:0]  op_stack [STACK_DEPTH];
  int unsigned op_depth = 0;

  // Postfix results still owed by the converter, oldest first
  result_t expected_postfix[$];
  result_t step_out[$];

  // Token stream under construction for the current expression
  token_t expr_q[$];

  int unsigned tokens_taken   = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Sender and receiver knobs
  bit          tx_bursty  = 1'b0;
  int unsigned burst_left = 0;
  rx_mode_t    rx_mode    = RX_OPEN;
  bit          hold_req   = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned run_left   = 0;
  bit          rx_on      = 1'b0;

  infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) DUT (
    .clk          (clk),
    .rst          (rst),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token        (token),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Shunting-yard model
  // --------------------------------------------------------------------------

  function automatic int unsigned precedence(logic [2:0] code);
    case (code)
      OP_MUL, OP_DIV, OP_MOD: return 2;
      OP_ADD, OP_SUB:         return 1;
      default:                return 0;  // stacked left paren binds loosest
    endcase
  endfunction

  function automatic void emit_result(logic [1:0] kind, logic [2:0] op,
                                      logic [31:0] value, logic [1:0] err);
    result_t r;
    r.out_kind   = kind;
    r.out_op     = op;
    r.out_value  = value;
    r.error_code = err;
    r.last       = 1'b0;
    step_out.push_back(r);
  endfunction

  // Push a code; on a full stack report overflow and clear the stack
  function automatic void push_code(logic [2:0] code);
    if (op_depth >= STACK_DEPTH) begin
      emit_result(KIND_ERROR, '0, '0, ERR_OVERFLOW);
      op_depth = 0;
    end else begin
      op_stack[op_depth] = code;
      op_depth++;
    end
  endfunction

  // Advance the model by one accepted token and queue what it releases
  function automatic void convert_token(token_t t);
    logic [2:0] top;
    bit         found;
    result_t    r;
    // Unknown commands and unknown operators leave no trace
    if (t.cmd > CMD_END || (t.cmd == CMD_OPERATOR && t.op_code > OP_MOD))
      return;
    tokens_taken++;
    step_out.delete();
    found = 1'b0;
    case (t.cmd)
      CMD_NUMBER: emit_result(KIND_NUMBER, '0, t.number_value, ERR_NONE);
      CMD_OPERATOR: begin
        while (op_depth > 0 &&
               precedence(op_stack[op_depth - 1]) >= precedence(t.op_code)) begin
          op_depth--;
          emit_result(KIND_OPERATOR, op_stack[op_depth], '0, ERR_NONE);
        end
        push_code(t.op_code);
      end
      CMD_LPAREN: push_code(CODE_LPAREN);
      default: begin
        // Right paren and end both unwind down to the nearest left paren
        while (op_depth > 0 && !found) begin
          op_depth--;
          top = op_stack[op_depth];
          if (top == CODE_LPAREN)
            found = 1'b1;
          else
            emit_result(KIND_OPERATOR, top, '0, ERR_NONE);
        end
        if (t.cmd == CMD_RPAREN) begin
          if (!found) begin
            emit_result(KIND_ERROR, '0, '0, ERR_RPAREN);
            op_depth = 0;
          end
        end else begin
          if (found)
            emit_result(KIND_ERROR, '0, '0, ERR_LPAREN);
          else
            emit_result(KIND_END, '0, '0, ERR_NONE);
          op_depth = 0;
        end
      end
    endcase
    // Mark the final result of this token
    foreach (step_out[i]) begin
      r = step_out[i];
      r.last = (i == step_out.size() - 1);
      expected_postfix.push_back(r);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  function automatic void compare_field(string name, logic [31:0] want,
                                        logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    if (expected_postfix.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: expected no result, actual kind %0d op %0d value %0h err %0d last %0d",
                 $time, got.out_kind, got.out_op, got.out_value, got.error_code, got.last);
      return;
    end
    want = expected_postfix.pop_front();
    compare_field("out_kind",   want.out_kind,   got.out_kind);
    compare_field("out_op",     want.out_op,     got.out_op);
    compare_field("out_value",  want.out_value,  got.out_value);
    compare_field("error_code", want.error_code, got.error_code);
    compare_field("last",       want.last,       got.last);
  endfunction

  // Observe both channels at each edge. A token accepted at this edge cannot
  // produce a result at the same edge, so predict first, then check.
  always @(posedge clk) begin
    if (!rst) begin
      if (token_valid && token_ready)
        convert_token(token);
      if (result_valid && result_ready)
        check_result(result);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern plus an optional long hold-off
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: result_ready <= 1'b1;
        RX_COIN: result_ready <= 1'($urandom_range(0, 1));
        default: begin
          // Alternate ready and stall runs of random length
          if (run_left == 0) begin
            rx_on    = !rx_on;
            run_left = rx_on ? $urandom_range(1, 8) : $urandom_range(1, 5);
          end
          run_left--;
          result_ready <= rx_on;
        end
      endcase
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("infix_to_postfix_converter regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Token builders
  // --------------------------------------------------------------------------

  // Fields the command does not use carry random bits
  function automatic token_t tok(logic [2:0] cmd);
    token_t t;
    t.cmd          = cmd;
    t.op_code      = 3'($urandom_range(0, 7));
    t.number_value = $urandom;
    return t;
  endfunction

  function automatic token_t op_tok(logic [2:0] op);
    token_t t;
    t         = tok(CMD_OPERATOR);
    t.op_code = op;
    return t;
  endfunction

  function automatic token_t num_tok(logic [31:0] value);
    token_t t;
    t              = tok(CMD_NUMBER);
    t.number_value = value;
    return t;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic token_t junk_tok();
    token_t t;
    t.cmd          = 3'($urandom_range(0, 7));
    t.op_code      = 3'($urandom_range(0, 7));
    t.number_value = $urandom;
    return t;
  endfunction

  // term := number | ( expr ) ; expr := term { op term }
  function automatic void add_term(int unsigned lvl);
    if (lvl > 0 && $urandom_range(0, 2) == 0) begin
      expr_q.push_back(tok(CMD_LPAREN));
      add_expr(lvl - 1);
      expr_q.push_back(tok(CMD_RPAREN));
    end else begin
      expr_q.push_back(num_tok(pick_value()));
    end
  endfunction

  function automatic void add_expr(int unsigned lvl);
    int unsigned terms;
    terms = $urandom_range(0, 4);
    add_term(lvl);
    repeat (terms) begin
      expr_q.push_back(op_tok(3'($urandom_range(OP_ADD, OP_MOD))));
      add_term(lvl);
    end
  endfunction

  // Mostly well-formed expressions; the rest broken or pure noise
  function automatic void build_expression();
    int unsigned shape;
    int unsigned pos;
    shape = $urandom_range(0, 11);
    expr_q.delete();
    case (shape)
      0: repeat ($urandom_range(4, 12)) expr_q.push_back(junk_tok());
      1: begin
        // Deep nesting: long unwinds, sometimes overflow
        repeat ($urandom_range(8, 30)) begin
          expr_q.push_back(tok(CMD_LPAREN));
          if ($urandom_range(0, 1)) begin
            expr_q.push_back(num_tok(pick_value()));
            expr_q.push_back(op_tok(3'($urandom_range(OP_ADD, OP_MOD))));
          end
        end
        add_expr(1);
        repeat ($urandom_range(0, 30)) expr_q.push_back(tok(CMD_RPAREN));
        expr_q.push_back(tok(CMD_END));
      end
      2: begin
        add_expr(3);
        expr_q.push_back(tok(CMD_END));
        pos = $urandom_range(0, expr_q.size() - 1);
        expr_q.delete(pos);
      end
      3: begin
        add_expr(3);
        expr_q.push_back(tok(CMD_END));
        pos = $urandom_range(0, expr_q.size() - 1);
        expr_q.insert(pos, junk_tok());
      end
      4: add_expr(3);  // no end: leftovers carry into the next expression
      5: begin
        add_expr(2);
        expr_q.push_back(tok(CMD_RPAREN));
        expr_q.push_back(tok(CMD_END));
      end
      default: begin
        add_expr(3);
        expr_q.push_back(tok(CMD_END));
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offer one token, hold it until accepted, then maybe open a gap
  task automatic send_token(input token_t t);
    int unsigned gap;
    token_valid <= 1'b1;
    token       <= t;
    @(posedge clk);
    while (!token_ready) @(posedge clk);
    if (tx_bursty) begin
      if (burst_left > 0)
        burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, 6);
        token_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_queue();
    foreach (expr_q[i]) send_token(expr_q[i]);
  endtask

  // Stop offering and wait until every owed result is out, then let any
  // walk on a silent token finish
  task automatic drain_results();
    token_valid <= 1'b0;
    while (expected_postfix.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_directed();
    rx_mode   = RX_OPEN;
    tx_bursty = 1'b0;
    // Operand extremes, + * - with precedence
    send_token(num_tok(32'h8000_0000));
    send_token(op_tok(OP_ADD));
    send_token(num_tok(32'h7fff_ffff));
    send_token(op_tok(OP_MUL));
    send_token(num_tok('0));
    send_token(op_tok(OP_SUB));
    send_token(num_tok('1));
    send_token(tok(CMD_END));
    // Nested parens, / and % left-associative, silent outer right paren
    send_token(tok(CMD_LPAREN));
    send_token(tok(CMD_LPAREN));
    send_token(num_tok(pick_value()));
    send_token(op_tok(OP_DIV));
    send_token(num_tok(pick_value()));
    send_token(op_tok(OP_MOD));
    send_token(num_tok(pick_value()));
    send_token(tok(CMD_RPAREN));
    send_token(tok(CMD_RPAREN));
    send_token(tok(CMD_END));
    // Unknown commands and an unknown operator
    send_token(tok(3'd5));
    send_token(tok(3'd7));
    send_token(op_tok(3'd7));
    // Unmatched right paren after an operator
    send_token(num_tok(pick_value()));
    send_token(op_tok(OP_ADD));
    send_token(tok(CMD_RPAREN));
    // Leftover left paren at end, end on an empty stack
    send_token(tok(CMD_LPAREN));
    send_token(op_tok(OP_SUB));
    send_token(tok(CMD_END));
    send_token(tok(CMD_END));
    drain_results();
  endtask

  task automatic test_overflow();
    rx_mode   = RX_PATTERN;
    tx_bursty = 1'b1;
    // Left paren pushed onto a full stack
    repeat (STACK_DEPTH + 1) send_token(tok(CMD_LPAREN));
    // Operator pushed onto a full stack, nothing to pop below it
    repeat (STACK_DEPTH - 1) send_token(tok(CMD_LPAREN));
    send_token(op_tok(OP_ADD));
    send_token(op_tok(OP_MUL));
    send_token(tok(CMD_END));
    drain_results();
  endtask

  task automatic test_backpressure();
    rx_mode   = RX_OPEN;
    tx_bursty = 1'b0;
    hold_req  = 1'b1;
    // Keep offering while the receiver holds off so the converter backs up
    repeat (4) begin
      expr_q.delete();
      add_expr(3);
      expr_q.push_back(tok(CMD_END));
      send_queue();
    end
    drain_results();
  endtask

  task automatic test_random();
    int unsigned start;
    start = tokens_taken;
    while (tokens_taken - start < RANDOM_ITEMS) begin
      // Reshuffle both sides now and then, including no-idle stretches
      if ($urandom_range(0, 5) == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        tx_bursty = 1'($urandom_range(0, 1));
      end
      build_expression();
      send_queue();
      if ($urandom_range(0, 15) == 0)
        drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    test_backpressure();
    test_random();
    if (expected_postfix.size() != 0) begin
      mismatch_count++;
      $display("%0t: expected %0d more results, actual none", $time,
               expected_postfix.size());
    end
    if (mismatch_count == 0)
      $display("infix_to_postfix_converter regression: pass");
    else
      $display("infix_to_postfix_converter regression: fail");
    $finish;
  end

endmodule
